[src/mrss_pkg.sv]
// Shared types and constants for the Morton range split search block.
// No dependencies; used by mrss_engine and morton_range_split_search.
package mrss_pkg;

   localparam int IDX_BITS       = 10;   // store index fields, fixed width
   localparam int CODE_IN_BITS   = 30;   // write_code field width
   localparam int REQ_TDATA_BITS = 64;   // 60 payload bits, zero padded
   localparam int RSP_TDATA_BITS = 16;   // 10 payload bits, zero padded

   // opcode, carried on req_tuser
   localparam logic OP_WRITE = 1'b0;
   localparam logic OP_SPLIT = 1'b1;

   typedef struct packed {
      logic                    opcode;
      logic [IDX_BITS-1:0]     write_index;
      logic [CODE_IN_BITS-1:0] write_code;
      logic [IDX_BITS-1:0]     range_first;
      logic [IDX_BITS-1:0]     range_last;
   } req_type;

   typedef struct packed {
      logic                bad_range;
      logic [IDX_BITS-1:0] split_index;
   } rsp_type;

   typedef enum logic [5:0] {
      S_IDLE  = 6'b000001,
      S_BASE  = 6'b000010,
      S_DIFF  = 6'b000100,
      S_PROBE = 6'b001000,
      S_CHECK = 6'b010000,
      S_DONE  = 6'b100000
   } state_type;

endpackage

[src/mrss_ram.sv]
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
module mrss_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[addr] <= wdata;
      end
      rdata_ff <= mem[addr];
   end

   assign rdata = rdata_ff;

endmodule

[src/mrss_engine.sv]
// Search sequencer: store writes, endpoint reads and the halving-step probe loop.
// Depends on mrss_pkg; drives one port of an mrss_ram instance.
module mrss_engine #(
   parameter int STORE_DEPTH = 1024,
   parameter int CODE_BITS   = 30,
   parameter int ADDR_BITS   = $clog2(STORE_DEPTH)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  mrss_pkg::req_type     req,
   output logic                  mem_we,
   output logic [ADDR_BITS-1:0]  mem_addr,
   output logic [CODE_BITS-1:0]  mem_wdata,
   input  logic [CODE_BITS-1:0]  mem_rdata,
   output logic                  res_valid,
   input  logic                  res_ready,
   output mrss_pkg::rsp_type     res
);

   localparam int IW = mrss_pkg::IDX_BITS;

   // index modulo STORE_DEPTH by conditional subtraction of shifted depths
   function automatic logic [ADDR_BITS-1:0] wrap_idx(input logic [IW-1:0] idx);
      logic [IW-1:0] r;
      r = idx;
      for (int k = IW - 1; k >= 0; k--) begin
         if (32'(r) >= (STORE_DEPTH << k)) begin
            r = r - IW'(STORE_DEPTH << k);
         end
      end
      return ADDR_BITS'(r);
   endfunction

   mrss_pkg::state_type state_ff, state_in;
   logic [IW-1:0]        first_ff, first_in;
   logic [IW-1:0]        last_ff, last_in;
   logic [IW-1:0]        split_ff, split_in;
   logic [IW-1:0]        step_ff, step_in;
   logic [IW-1:0]        probe_ff, probe_in;
   logic                 bad_ff, bad_in;
   logic [CODE_BITS-1:0] base_ff, base_in;
   logic [CODE_BITS-1:0] diff_ff, diff_in;

   logic                 accept;
   logic [IW:0]          step_inc;
   logic [IW-1:0]        step_next;
   logic [IW:0]          probe_sum;
   logic                 probe_in_range;
   logic [CODE_BITS-1:0] probe_xor;
   logic                 longer_prefix;

   assign req_ready = (state_ff == mrss_pkg::S_IDLE);
   assign accept    = req_valid && req_ready;

   assign step_inc       = {1'b0, step_ff} + (IW + 1)'(1);
   assign step_next      = step_inc[IW:1];
   assign probe_sum      = {1'b0, split_ff} + {1'b0, step_next};
   assign probe_in_range = probe_sum < {1'b0, last_ff};

   // top set bit of x below top set bit of diff, without a priority encoder
   assign probe_xor     = base_ff ^ mem_rdata;
   assign longer_prefix = (probe_xor < diff_ff) && (probe_xor < (probe_xor ^ diff_ff));

   always_comb begin
      mem_we    = accept && (req.opcode == mrss_pkg::OP_WRITE);
      mem_wdata = CODE_BITS'(req.write_code);
      mem_addr  = wrap_idx(last_ff);
      unique case (state_ff)
         mrss_pkg::S_IDLE: begin
            mem_addr = (req.opcode == mrss_pkg::OP_WRITE) ? wrap_idx(req.write_index)
                                                          : wrap_idx(req.range_first);
         end
         mrss_pkg::S_PROBE: begin
            mem_addr = wrap_idx(probe_sum[IW-1:0]);
         end
         default: begin
            mem_addr = wrap_idx(last_ff);
         end
      endcase
   end

   always_comb begin
      state_in = state_ff;
      first_in = first_ff;
      last_in  = last_ff;
      split_in = split_ff;
      step_in  = step_ff;
      probe_in = probe_ff;
      bad_in   = bad_ff;
      base_in  = base_ff;
      diff_in  = diff_ff;
      unique case (state_ff)
         mrss_pkg::S_IDLE: begin
            if (accept && (req.opcode == mrss_pkg::OP_SPLIT)) begin
               first_in = req.range_first;
               last_in  = req.range_last;
               split_in = req.range_first;
               step_in  = req.range_last - req.range_first;
               bad_in   = req.range_first > req.range_last;
               // reversed or single-element range needs no store access
               state_in = (req.range_first >= req.range_last) ? mrss_pkg::S_DONE
                                                              : mrss_pkg::S_BASE;
            end
         end
         mrss_pkg::S_BASE: begin
            base_in  = mem_rdata;
            state_in = mrss_pkg::S_DIFF;
         end
         mrss_pkg::S_DIFF: begin
            diff_in  = base_ff ^ mem_rdata;
            state_in = ((base_ff ^ mem_rdata) == '0) ? mrss_pkg::S_DONE : mrss_pkg::S_PROBE;
         end
         mrss_pkg::S_PROBE: begin
            step_in  = step_next;
            probe_in = probe_sum[IW-1:0];
            if (probe_in_range) begin
               state_in = mrss_pkg::S_CHECK;
            end else if (step_next > IW'(1)) begin
               state_in = mrss_pkg::S_PROBE;
            end else begin
               state_in = mrss_pkg::S_DONE;
            end
         end
         mrss_pkg::S_CHECK: begin
            if (longer_prefix) begin
               split_in = probe_ff;
            end
            state_in = (step_ff > IW'(1)) ? mrss_pkg::S_PROBE : mrss_pkg::S_DONE;
         end
         mrss_pkg::S_DONE: begin
            if (res_ready) begin
               state_in = mrss_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = mrss_pkg::S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= mrss_pkg::S_IDLE;
      end else begin
         state_ff <= state_in;
      end
      first_ff <= first_in;
      last_ff  <= last_in;
      split_ff <= split_in;
      step_ff  <= step_in;
      probe_ff <= probe_in;
      bad_ff   <= bad_in;
      base_ff  <= base_in;
      diff_ff  <= diff_in;
   end

   assign res_valid       = (state_ff == mrss_pkg::S_DONE);
   assign res.split_index = split_ff;
   assign res.bad_range   = bad_ff;

`ifndef NO_ASSERTIONS
   // the split never reaches the last index while the search runs
   a_split_below_last: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrss_pkg::S_PROBE || state_ff == mrss_pkg::S_CHECK)
         |-> (split_ff < last_ff))
      else $error("split reached range_last during search");

   // a probe is only read when it lies strictly inside the range
   a_probe_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrss_pkg::S_CHECK) |-> (probe_ff < last_ff && probe_ff > split_ff))
      else $error("probe outside the open range");

   // step halves (rounded up) at every probe
   a_step_shrinks: assert property (@(posedge clock) disable iff (reset)
      (state_ff == mrss_pkg::S_PROBE) |=> (step_ff < $past(step_ff) || step_ff == IW'(1)))
      else $error("search step did not shrink");

   // store writes happen only between queries
   a_write_idle: assert property (@(posedge clock) disable iff (reset)
      mem_we |-> (state_ff == mrss_pkg::S_IDLE && req.opcode == mrss_pkg::OP_WRITE))
      else $error("store write outside idle");

   // a bad range result reports first, which lies above last
   a_bad_result: assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.bad_range) |-> (res.split_index == first_ff && first_ff > last_ff))
      else $error("bad range result inconsistent");
`endif

endmodule

[src/morton_range_split_search.sv]
// Top level of the Morton range split search block: stream ports, store RAM,
// search engine and output register. Depends on mrss_pkg, mrss_ram, mrss_engine.

// One transaction at a time: a write transaction completes in the cycle it is
// accepted. A split query goes straight to its result when the range is
// reversed or one element; otherwise it reads both endpoint codes, finishes
// when they match, and else enters the probe loop, where a probe that lands at
// or beyond the last index skips its compare state. The loop runs around the
// single-port code store: each probe address depends on the previous probe's
// registered read data, so each halving step passes through an address state
// and a compare state. The finished result sits in an output register, so
// the next request is taken while the response still waits for rsp_tready.
// Store entries must be written before a query reads them; unwritten entries
// return arbitrary codes. Indices wrap modulo STORE_DEPTH.
module morton_range_split_search #(
   parameter int STORE_DEPTH = 1024,
   parameter int CODE_BITS   = 30
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // [9:0] write_index, [39:10] write_code, [49:40] range_first,
   // [59:50] range_last, [63:60] zero
   input  logic [mrss_pkg::REQ_TDATA_BITS-1:0] req_tdata,
   // [0] opcode
   input  logic                                req_tuser,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // [9:0] split_index, [15:10] zero
   output logic [mrss_pkg::RSP_TDATA_BITS-1:0] rsp_tdata,
   // [0] bad_range
   output logic                                rsp_tuser
);

   localparam int ADDR_BITS = $clog2(STORE_DEPTH);
   localparam int IW        = mrss_pkg::IDX_BITS;
   localparam int CW        = mrss_pkg::CODE_IN_BITS;

   mrss_pkg::req_type req;
   mrss_pkg::rsp_type res;
   mrss_pkg::rsp_type rsp_ff, rsp_in;
   logic              rsp_valid_ff, rsp_valid_in;

   logic                 res_valid;
   logic                 res_ready;
   logic                 mem_we;
   logic [ADDR_BITS-1:0] mem_addr;
   logic [CODE_BITS-1:0] mem_wdata;
   logic [CODE_BITS-1:0] mem_rdata;

   // unpack the request transaction
   assign req.opcode      = req_tuser;
   assign req.write_index = req_tdata[IW-1:0];
   assign req.write_code  = req_tdata[IW+CW-1:IW];
   assign req.range_first = req_tdata[2*IW+CW-1:IW+CW];
   assign req.range_last  = req_tdata[3*IW+CW-1:2*IW+CW];

   mrss_ram #(
      .WIDTH (CODE_BITS),
      .DEPTH (STORE_DEPTH)
   ) u_code_store (
      .clock (clock),
      .we    (mem_we),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   mrss_engine #(
      .STORE_DEPTH (STORE_DEPTH),
      .CODE_BITS   (CODE_BITS),
      .ADDR_BITS   (ADDR_BITS)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req       (req),
      .mem_we    (mem_we),
      .mem_addr  (mem_addr),
      .mem_wdata (mem_wdata),
      .mem_rdata (mem_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register: loads when empty or being drained this cycle
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (res_ready) begin
         rsp_valid_in = res_valid;
         if (res_valid) begin
            rsp_in = res;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = mrss_pkg::RSP_TDATA_BITS'(rsp_ff.split_index);
   assign rsp_tuser  = rsp_ff.bad_range;

endmodule
